>>> hdl/three_channel_moving_average_calib_core_macros.svh
// Assertion macros for the three-channel moving average calibration core.
// Included by the top level; no other dependencies.
`ifndef THREE_CHANNEL_MOVING_AVERAGE_CALIB_CORE_MACROS_SVH
`define THREE_CHANNEL_MOVING_AVERAGE_CALIB_CORE_MACROS_SVH

`ifndef SYNTH

// Condition must hold at every sampled clock edge outside reset.
`define TCMA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("tcma assertion failed");

// Consequence must hold in the cycle after the trigger.
`define TCMA_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("tcma assertion failed");

// Consequence must hold a fixed number of cycles after the trigger.
`define TCMA_ASSERT_LATER(label, clk, rst, trig, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> ##(dly) (cons)) \
      else $error("tcma assertion failed");

`else

`define TCMA_ASSERT_ALWAYS(label, clk, rst, cond)
`define TCMA_ASSERT_NEXT(label, clk, rst, trig, cons)
`define TCMA_ASSERT_LATER(label, clk, rst, trig, dly, cons)

`endif

`endif

>>> hdl/tcma_pkg.sv
// Shared types, constants and scaling tables of the moving average calibration core.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package tcma_pkg;

   localparam int unsigned SAMPLE_W       = 12;
   localparam int unsigned VOLT_W         = 13;
   localparam int unsigned CURR_W         = 12;
   localparam int unsigned LANES          = 3;
   localparam int unsigned SAMPLE_MAX     = 4095;
   localparam int unsigned WINDOW_DEFAULT = 30;

   // Width of a scaling multiplier constant and of its shift amount.
   localparam int unsigned K_W = 41;
   localparam int unsigned S_W = 6;

   // Delay from an accepted item until its result is shown when the receiver does not stall.
   localparam int unsigned RSP_LATENCY = 14;

   localparam logic [1:0] LANE_VOLT = 2'd0;
   localparam logic [1:0] LANE_CURR = 2'd1;
   localparam logic [1:0] LANE_PEER = 2'd2;

   typedef enum logic [2:0] {
      STEP_MEAN,
      STEP_GAIN,
      STEP_DIV15,
      STEP_RECIP,
      STEP_TRIM
   } step_type;

   localparam step_type STEP_LAST = STEP_TRIM;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_SHIFT,
      ST_BAND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     capture;
      logic     load;
      logic     mul;
      logic     shift;
      logic     band;
      logic     out_load;
      step_type step;
   } cmd_type;

   // Every scaling step computes floor(x * NUM / DEN) for x up to XMAX as
   // (x * K) >> S with K = NUM * ceil(2^S / DEN) and 2^S > XMAX * NUM * DEN,
   // which makes the result exact.
   localparam longint unsigned XMAX = 64'(SAMPLE_MAX);

   localparam longint unsigned V_NUM  = 10000;
   localparam longint unsigned V_DEN  = 12432;
   localparam longint unsigned C_NUM  = 10000;
   localparam longint unsigned C_DEN  = 12340;
   localparam longint unsigned D_NUM  = 1;
   localparam longint unsigned D_DEN  = 15;
   localparam longint unsigned R_NUM  = 10000;
   localparam longint unsigned R_DEN  = 1017;
   localparam longint unsigned CT_NUM = 1013;
   localparam longint unsigned CT_DEN = 1000;
   localparam longint unsigned PT_NUM = 10255;
   localparam longint unsigned PT_DEN = 10000;
   localparam longint unsigned BH_NUM = 1019;
   localparam longint unsigned BH_DEN = 1000;
   localparam longint unsigned BM_NUM = 99;
   localparam longint unsigned BM_DEN = 100;
   localparam longint unsigned BU_NUM = 1012;
   localparam longint unsigned BU_DEN = 1000;
   localparam longint unsigned VOLT_SCALE = 2;

   localparam int unsigned     V_S  = $clog2(XMAX * V_NUM * V_DEN + 1);
   localparam longint unsigned V_K  = V_NUM * (((64'd1 << V_S) + V_DEN - 1) / V_DEN);
   localparam int unsigned     C_S  = $clog2(XMAX * C_NUM * C_DEN + 1);
   localparam longint unsigned C_K  = C_NUM * (((64'd1 << C_S) + C_DEN - 1) / C_DEN);
   localparam int unsigned     D_S  = $clog2(XMAX * D_NUM * D_DEN + 1);
   localparam longint unsigned D_K  = D_NUM * (((64'd1 << D_S) + D_DEN - 1) / D_DEN);
   localparam int unsigned     R_S  = $clog2(XMAX * R_NUM * R_DEN + 1);
   localparam longint unsigned R_K  = R_NUM * (((64'd1 << R_S) + R_DEN - 1) / R_DEN);
   localparam int unsigned     CT_S = $clog2(XMAX * CT_NUM * CT_DEN + 1);
   localparam longint unsigned CT_K = CT_NUM * (((64'd1 << CT_S) + CT_DEN - 1) / CT_DEN);
   localparam int unsigned     PT_S = $clog2(XMAX * PT_NUM * PT_DEN + 1);
   localparam longint unsigned PT_K = PT_NUM * (((64'd1 << PT_S) + PT_DEN - 1) / PT_DEN);
   localparam int unsigned     BH_S = $clog2(XMAX * BH_NUM * BH_DEN + 1);
   localparam longint unsigned BH_K = BH_NUM * (((64'd1 << BH_S) + BH_DEN - 1) / BH_DEN);
   localparam int unsigned     BM_S = $clog2(XMAX * BM_NUM * BM_DEN + 1);
   localparam longint unsigned BM_K = BM_NUM * (((64'd1 << BM_S) + BM_DEN - 1) / BM_DEN);
   localparam int unsigned     BU_S = $clog2(XMAX * BU_NUM * BU_DEN + 1);
   localparam longint unsigned BU_K = BU_NUM * (((64'd1 << BU_S) + BU_DEN - 1) / BU_DEN);

   // Limits of the gain bands, keyed on the calibrated peer current.
   localparam logic [CURR_W-1:0] BAND_HI_LIM  = CURR_W'(900);
   localparam logic [CURR_W-1:0] BAND_MID_LO  = CURR_W'(450);
   localparam logic [CURR_W-1:0] BAND_MID_HI  = CURR_W'(550);
   localparam logic [CURR_W-1:0] BAND_UP_LO   = CURR_W'(650);
   localparam logic [CURR_W-1:0] BAND_UP_HI   = CURR_W'(750);

   // Multiplier constant of a lane for a chain step after the mean.
   function automatic logic [K_W-1:0] step_gain(input logic [1:0] lane, input step_type step);
      logic [K_W-1:0] k;
      k = K_W'(1);
      unique case (step)
         STEP_GAIN:  k = (lane == LANE_VOLT) ? K_W'(V_K) : K_W'(C_K);
         STEP_DIV15: k = (lane == LANE_VOLT) ? K_W'(1) : K_W'(D_K);
         STEP_RECIP: k = (lane == LANE_VOLT) ? K_W'(1) : K_W'(R_K);
         STEP_TRIM: begin
            if (lane == LANE_VOLT) k = K_W'(VOLT_SCALE);
            else if (lane == LANE_CURR) k = K_W'(CT_K);
            else k = K_W'(PT_K);
         end
         default: k = K_W'(1);
      endcase
      return k;
   endfunction

   // Shift amount matching step_gain.
   function automatic logic [S_W-1:0] step_shift(input logic [1:0] lane, input step_type step);
      logic [S_W-1:0] s;
      s = '0;
      unique case (step)
         STEP_GAIN:  s = (lane == LANE_VOLT) ? S_W'(V_S) : S_W'(C_S);
         STEP_DIV15: s = (lane == LANE_VOLT) ? '0 : S_W'(D_S);
         STEP_RECIP: s = (lane == LANE_VOLT) ? '0 : S_W'(R_S);
         STEP_TRIM: begin
            if (lane == LANE_VOLT) s = '0;
            else if (lane == LANE_CURR) s = S_W'(CT_S);
            else s = S_W'(PT_S);
         end
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic step_type next_step(input step_type step);
      step_type n;
      n = STEP_MEAN;
      unique case (step)
         STEP_MEAN:  n = STEP_GAIN;
         STEP_GAIN:  n = STEP_DIV15;
         STEP_DIV15: n = STEP_RECIP;
         STEP_RECIP: n = STEP_TRIM;
         default:    n = STEP_MEAN;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

>>> hdl/three_channel_moving_average_calib_core.sv
// Three-channel boxcar moving average with calibration: top level.
// Depends on tcma_pkg, tcma_ctrl, tcma_dpath and the assertion macro header.
//
// Usage. Each input transfer on the req_ channel carries one triple of raw
// 12-bit converter samples: bus voltage, own current and peer current. Each
// transfer on the rsp_ channel returns exactly one result: the calibrated
// windowed voltage (hundredths of a volt), both calibrated currents
// (milliamps) and the current-sharing target. Both channels use valid/ready.
// Sequence: the input transfer reads the ring, then the running sums are
// updated, then the five chain steps each pass through the lane multiplier
// and then the shifter, then the gain band step runs and the result
// register is loaded. A new input is taken in the cycle after that result
// is loaded, so the block does not take a new item before it is through
// with the last one.
// A finished result waits in the output register while the next input is
// already being taken; if the receiver still holds off when the following
// result is ready, the controller waits and req_ready stays low.
// Reset clears the running sums, the ring valid bits and the slot pointer,
// so the window starts empty (all zero) and the first means are pulled low.
`default_nettype none
`include "three_channel_moving_average_calib_core_macros.svh"

module three_channel_moving_average_calib_core #(
   parameter int unsigned WINDOW = tcma_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcma_pkg::SAMPLE_W-1:0] req_voltage_sample,
   input  logic [tcma_pkg::SAMPLE_W-1:0] req_current_sample,
   input  logic [tcma_pkg::SAMPLE_W-1:0] req_peer_current_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tcma_pkg::VOLT_W-1:0]   rsp_voltage_mean,
   output logic [tcma_pkg::CURR_W-1:0]   rsp_current_mean,
   output logic [tcma_pkg::CURR_W-1:0]   rsp_peer_current_mean,
   output logic [tcma_pkg::CURR_W-1:0]   rsp_share_target
);
   import tcma_pkg::*;

   // Command word from the controller to the datapath.
   cmd_type    cmd;
   logic [5:0] cmd_strobes;

   assign cmd_strobes = {cmd.capture, cmd.load, cmd.mul, cmd.shift, cmd.band, cmd.out_load};

   tcma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath keeps the ring and sums, and holds the result register
   // that separates the result transfer from the work on the next item.
   tcma_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .voltage_sample      (req_voltage_sample),
      .current_sample      (req_current_sample),
      .peer_current_sample (req_peer_current_sample),
      .voltage_mean        (rsp_voltage_mean),
      .current_mean        (rsp_current_mean),
      .peer_current_mean   (rsp_peer_current_mean),
      .share_target        (rsp_share_target)
   );

   // The controller issues at most one datapath command per cycle.
   `TCMA_ASSERT_ALWAYS(a_one_cmd, clock, reset, $onehot0(cmd_strobes))

   // Loading the result register always presents a result.
   `TCMA_ASSERT_NEXT(a_load_shows, clock, reset, cmd.out_load, rsp_valid)

   // A result is on show RSP_LATENCY after each accepted item.
   `TCMA_ASSERT_LATER(a_latency, clock, reset, req_valid && req_ready, RSP_LATENCY, rsp_valid)

endmodule

`default_nettype wire

>>> hdl/tcma_ctrl.sv
// Controller of the moving average calibration core: sequences the datapath.
// Depends on tcma_pkg for the state, step and command types.
`default_nettype none

module tcma_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcma_pkg::cmd_type cmd
);
   import tcma_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_MUL;
            step_in  = STEP_MEAN;
         end
         ST_MUL: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_BAND;
            end else begin
               state_in = ST_MUL;
               step_in  = next_step(step_ff);
            end
         end
         ST_BAND: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.step  = step_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_LOAD:  cmd.load  = 1'b1;
         ST_MUL:   cmd.mul   = 1'b1;
         ST_SHIFT: cmd.shift = 1'b1;
         ST_BAND:  cmd.band  = 1'b1;
         ST_DONE:  cmd.out_load = !rsp_valid_ff || rsp_ready;
         default:  cmd.out_load = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_MEAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hdl/tcma_dpath.sv
// Datapath of the moving average calibration core: sample ring, running sums,
// three scaling lanes, the sharing-target unit and the result register.
// Depends on tcma_pkg for widths, scaling constants and the command type.
`default_nettype none

module tcma_dpath #(
   parameter int unsigned WINDOW = tcma_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tcma_pkg::cmd_type             cmd,
   input  logic [tcma_pkg::SAMPLE_W-1:0] voltage_sample,
   input  logic [tcma_pkg::SAMPLE_W-1:0] current_sample,
   input  logic [tcma_pkg::SAMPLE_W-1:0] peer_current_sample,
   output logic [tcma_pkg::VOLT_W-1:0]   voltage_mean,
   output logic [tcma_pkg::CURR_W-1:0]   current_mean,
   output logic [tcma_pkg::CURR_W-1:0]   peer_current_mean,
   output logic [tcma_pkg::CURR_W-1:0]   share_target
);
   import tcma_pkg::*;

   localparam int unsigned SUM_W   = $clog2(SAMPLE_MAX * WINDOW + 1);
   localparam int unsigned SLOT_W  = $clog2(WINDOW);
   localparam int unsigned OPER_W  = SUM_W;
   localparam int unsigned PROD_W  = OPER_W + K_W;
   localparam int unsigned ROW_W   = LANES * SAMPLE_W;
   localparam int unsigned SHARE_W = CURR_W + K_W;
   localparam int unsigned MEAN_S  = $clog2(XMAX * WINDOW * WINDOW + 1);
   localparam longint unsigned MEAN_K = ((64'd1 << MEAN_S) + WINDOW - 1) / WINDOW;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

   // Sample ring: one row holds the three samples of an item.
   logic [ROW_W-1:0]  ring_mem [WINDOW];
   logic [WINDOW-1:0] ring_vld_ff, ring_vld_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ROW_W-1:0]  row_rd_ff;
   logic              row_hit_ff;
   logic [ROW_W-1:0]  sample_ff;

   logic [OPER_W-1:0] lane_oper [LANES];

   logic [CURR_W-1:0]  t_half;
   logic [CURR_W-1:0]  peer_cal;
   logic [K_W-1:0]     band_k;
   logic [S_W-1:0]     band_s;
   logic [SHARE_W-1:0] share_prod_ff;
   logic [S_W-1:0]     share_shift_ff;

   logic [VOLT_W-1:0] vmean_ff;
   logic [CURR_W-1:0] cmean_ff;
   logic [CURR_W-1:0] pmean_ff;
   logic [CURR_W-1:0] share_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) ring_mem[slot_ff] <= sample_ff;
      if (cmd.capture) row_rd_ff <= ring_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_hit_ff <= ring_vld_ff[slot_ff];
         sample_ff  <= {peer_current_sample, current_sample, voltage_sample};
      end
   end

   always_comb begin
      ring_vld_in = ring_vld_ff;
      slot_in     = slot_ff;
      if (cmd.load) begin
         ring_vld_in[slot_ff] = 1'b1;
         slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
         slot_ff     <= '0;
      end else begin
         ring_vld_ff <= ring_vld_in;
         slot_ff     <= slot_in;
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [SAMPLE_W-1:0] old_sample;
      logic [SAMPLE_W-1:0] new_sample;
      logic [SUM_W-1:0]    sum_ff, sum_in;
      logic [OPER_W-1:0]   oper_ff, oper_in;
      logic [PROD_W-1:0]   prod_ff;
      logic [S_W-1:0]      shift_ff;
      logic [K_W-1:0]      k_sel;
      logic [S_W-1:0]      s_sel;

      // A slot never written counts as zero during warm-up.
      assign old_sample = row_hit_ff ? row_rd_ff[g*SAMPLE_W +: SAMPLE_W] : '0;
      assign new_sample = sample_ff[g*SAMPLE_W +: SAMPLE_W];

      always_comb begin
         sum_in = sum_ff;
         if (cmd.load) sum_in = sum_ff - SUM_W'(old_sample) + SUM_W'(new_sample);
      end

      always_ff @(posedge clock) begin
         if (reset) sum_ff <= '0;
         else sum_ff <= sum_in;
      end

      always_comb begin
         if (cmd.step == STEP_MEAN) begin
            k_sel = K_W'(MEAN_K);
            s_sel = S_W'(MEAN_S);
         end else begin
            k_sel = step_gain(2'(g), cmd.step);
            s_sel = step_shift(2'(g), cmd.step);
         end
      end

      always_comb begin
         oper_in = oper_ff;
         if (cmd.load) oper_in = sum_in;
         else if (cmd.shift) oper_in = OPER_W'(prod_ff >> shift_ff);
      end

      always_ff @(posedge clock) begin
         oper_ff <= oper_in;
         if (cmd.mul) begin
            prod_ff  <= PROD_W'(oper_ff) * PROD_W'(k_sel);
            shift_ff <= s_sel;
         end
      end

      assign lane_oper[g] = oper_ff;
   end

   // Sharing target: half the sum of the two calibrated currents, then a gain
   // band picked by the calibrated peer current. The bands do not overlap.
   assign peer_cal = lane_oper[LANE_PEER][CURR_W-1:0];
   assign t_half   = CURR_W'((SUM_W'(lane_oper[LANE_CURR][CURR_W-1:0])
                              + SUM_W'(peer_cal)) >> 1);

   always_comb begin
      band_k = K_W'(1);
      band_s = '0;
      if (peer_cal > BAND_HI_LIM) begin
         band_k = K_W'(BH_K);
         band_s = S_W'(BH_S);
      end else if (peer_cal > BAND_MID_LO && peer_cal < BAND_MID_HI) begin
         band_k = K_W'(BM_K);
         band_s = S_W'(BM_S);
      end else if (peer_cal > BAND_UP_LO && peer_cal < BAND_UP_HI) begin
         band_k = K_W'(BU_K);
         band_s = S_W'(BU_S);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.band) begin
         share_prod_ff  <= SHARE_W'(t_half) * SHARE_W'(band_k);
         share_shift_ff <= band_s;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         vmean_ff <= lane_oper[LANE_VOLT][VOLT_W-1:0];
         cmean_ff <= lane_oper[LANE_CURR][CURR_W-1:0];
         pmean_ff <= peer_cal;
         share_ff <= CURR_W'(share_prod_ff >> share_shift_ff);
      end
   end

   assign voltage_mean      = vmean_ff;
   assign current_mean      = cmean_ff;
   assign peer_current_mean = pmean_ff;
   assign share_target      = share_ff;

endmodule

`default_nettype wire
